// File: hw/rtl/dltq_pkg.sv
// ============================================================================
// dltq_pkg
// Shared types and codes for the delta-list timeout queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dltq_pkg;

    localparam int DELTA_W  = 15;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_EXPIRED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd2;

    // Command codes handed from the front to the back.
    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK_HOLD = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT    = 2'd2;

    typedef struct packed {
        logic                func;
        logic [DELTA_W-1:0]  delay_ticks;
        logic [HANDLE_W-1:0] handle;
        logic                blocked;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] expired_handle;
        logic                last;
    } t_out;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [DELTA_W-1:0]  delay_ticks;
        logic [HANDLE_W-1:0] handle;
    } t_cmd;

    typedef struct packed {
        logic [DELTA_W-1:0]  delta;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

endpackage

`default_nettype wire

// File: hw/rtl/dltq_fifo.sv
// ============================================================================
// dltq_fifo
// Small first-in first-out register queue with a typed payload.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dltq_fifo #(
    parameter type t_data     = logic,
    parameter int  DEPTH_LOG2 = 1
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_data      i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_data      o_data,
    output logic       o_empty
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    t_data                 r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wr;
    logic [DEPTH_LOG2-1:0] r_rd;
    logic [DEPTH_LOG2:0]   r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_cnt == (DEPTH_LOG2+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dltq_front.sv
// ============================================================================
// dltq_front
// Accepts input items, classifies them into commands and queues them.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dltq_front (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  dltq_pkg::t_in i_item,
    input  wire logic     i_push,
    output logic          o_full,
    output dltq_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_pop
);

    dltq_pkg::t_cmd cmd;
    logic           cmd_empty;

    // A tick carries its blocked flag in the command code; the delay and
    // handle only matter for an insert.
    always_comb begin
        cmd.delay_ticks = i_item.delay_ticks;
        cmd.handle      = i_item.handle;
        if (i_item.func) begin
            cmd.op = dltq_pkg::OP_INSERT;
        end else if (i_item.blocked) begin
            cmd.op = dltq_pkg::OP_TICK_HOLD;
        end else begin
            cmd.op = dltq_pkg::OP_TICK;
        end
    end

    dltq_fifo #(
        .t_data     (dltq_pkg::t_cmd),
        .DEPTH_LOG2 (1)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (cmd_empty)
    );

    assign o_cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// File: hw/rtl/dltq_engine.sv
// ============================================================================
// dltq_engine
// Sequencer that walks, shifts, ages and compacts the delta table.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dltq_engine #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  dltq_pkg::t_cmd i_cmd,
    input  wire logic      i_cmd_valid,
    output logic           o_cmd_pop,
    output dltq_pkg::t_out o_res,
    output logic           o_res_push,
    input  wire logic      i_res_full
);

    localparam int AW = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] CAP = AW'(TABLE_ENTRIES - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WK_RD   = 4'd1;
    localparam logic [3:0] S_WK_CMP  = 4'd2;
    localparam logic [3:0] S_SH_RD   = 4'd3;
    localparam logic [3:0] S_SH_WR   = 4'd4;
    localparam logic [3:0] S_WR_NEXT = 4'd5;
    localparam logic [3:0] S_WR_NEW  = 4'd6;
    localparam logic [3:0] S_EMIT    = 4'd7;
    localparam logic [3:0] S_DC_RD   = 4'd8;
    localparam logic [3:0] S_DC_CHK  = 4'd9;
    localparam logic [3:0] S_FR_RD   = 4'd10;
    localparam logic [3:0] S_FR_CHK  = 4'd11;
    localparam logic [3:0] S_FR_END  = 4'd12;
    localparam logic [3:0] S_CP_INIT = 4'd13;
    localparam logic [3:0] S_CP_RD   = 4'd14;
    localparam logic [3:0] S_CP_WR   = 4'd15;

    dltq_pkg::t_entry r_mem [TABLE_ENTRIES];
    dltq_pkg::t_entry r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    dltq_pkg::t_entry mem_wdata;
    logic [AW-1:0]    mem_raddr;

    logic [3:0]                      r_state, n_state;
    logic [3:0]                      r_ret, n_ret;
    logic [AW-1:0]                   r_count, n_count;
    logic [AW-1:0]                   r_pos, n_pos;
    logic [AW-1:0]                   r_idx, n_idx;
    logic [dltq_pkg::DELTA_W-1:0]    r_t, n_t;
    logic [dltq_pkg::HANDLE_W-1:0]   r_h, n_h;
    logic                            r_blocked, n_blocked;
    dltq_pkg::t_entry                r_stop, n_stop;
    dltq_pkg::t_out                  r_res, n_res;

    logic [AW-1:0] pos_inc;
    logic [AW-1:0] idx_inc;
    logic [AW-1:0] idx_dec;

    assign pos_inc = r_pos + 1'b1;
    assign idx_inc = r_idx + 1'b1;
    assign idx_dec = r_idx - 1'b1;
    assign o_res   = r_res;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_count    = r_count;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_t        = r_t;
        n_h        = r_h;
        n_blocked  = r_blocked;
        n_stop     = r_stop;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = r_rdata;
        mem_raddr  = r_idx;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_t       = i_cmd.delay_ticks;
                    n_h       = i_cmd.handle;
                    n_pos     = '0;
                    n_idx     = '0;
                    n_blocked = (i_cmd.op == dltq_pkg::OP_TICK_HOLD);
                    if (i_cmd.op == dltq_pkg::OP_INSERT) begin
                        if (r_count == CAP) begin
                            n_res   = '{status: dltq_pkg::ST_REJECT,
                                        expired_handle: i_cmd.handle, last: 1'b1};
                            n_ret   = S_IDLE;
                            n_state = S_EMIT;
                        end else if (r_count == '0) begin
                            n_state = S_WR_NEW;
                        end else begin
                            n_state = S_WK_RD;
                        end
                    end else if (r_count != '0) begin
                        n_state = S_DC_RD;
                    end
                end
            end

            // Walk: subtract deltas while they do not exceed the remainder.
            S_WK_RD: begin
                mem_raddr = r_pos;
                n_state   = S_WK_CMP;
            end
            S_WK_CMP: begin
                if (r_rdata.delta <= r_t) begin
                    n_t   = r_t - r_rdata.delta;
                    n_pos = pos_inc;
                    if (pos_inc == r_count) begin
                        n_state = S_WR_NEW;
                    end else begin
                        n_state = S_WK_RD;
                    end
                end else begin
                    n_stop = r_rdata;
                    if (r_count > pos_inc) begin
                        n_idx   = r_count;
                        n_state = S_SH_RD;
                    end else begin
                        n_state = S_WR_NEXT;
                    end
                end
            end

            // Shift entries above the insertion point up by one place.
            S_SH_RD: begin
                mem_raddr = idx_dec;
                n_state   = S_SH_WR;
            end
            S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_rdata;
                n_idx     = idx_dec;
                if (idx_dec == pos_inc) begin
                    n_state = S_WR_NEXT;
                end else begin
                    n_state = S_SH_RD;
                end
            end

            // The entry displaced by the insert loses the new entry's delta.
            S_WR_NEXT: begin
                mem_we          = 1'b1;
                mem_waddr       = pos_inc;
                mem_wdata.delta = r_stop.delta - r_t;
                mem_wdata.handle = r_stop.handle;
                n_state         = S_WR_NEW;
            end
            S_WR_NEW: begin
                mem_we           = 1'b1;
                mem_waddr        = r_pos;
                mem_wdata.delta  = r_t;
                mem_wdata.handle = r_h;
                n_count          = r_count + 1'b1;
                n_res            = '{status: dltq_pkg::ST_ACCEPT,
                                     expired_handle: r_h, last: 1'b1};
                n_ret            = S_IDLE;
                n_state          = S_EMIT;
            end

            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = r_ret;
                end
            end

            // Tick: decrement the first positive delta.
            S_DC_RD: begin
                n_state = S_DC_CHK;
            end
            S_DC_CHK: begin
                if (r_rdata.delta != '0) begin
                    mem_we          = 1'b1;
                    mem_wdata.delta = r_rdata.delta - 1'b1;
                    n_idx           = '0;
                    n_state         = r_blocked ? S_IDLE : S_FR_RD;
                end else if (idx_inc == r_count) begin
                    n_idx   = '0;
                    n_state = r_blocked ? S_IDLE : S_FR_RD;
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_DC_RD;
                end
            end

            // Fire: each zero entry is held back one step so that the last
            // one of the run can carry the last mark. A held entry exists
            // exactly when the scan index is above zero.
            S_FR_RD: begin
                n_state = S_FR_CHK;
            end
            S_FR_CHK: begin
                if (r_rdata.delta == '0) begin
                    n_h   = r_rdata.handle;
                    n_idx = idx_inc;
                    if (r_idx != '0) begin
                        n_res   = '{status: dltq_pkg::ST_EXPIRED,
                                    expired_handle: r_h, last: 1'b0};
                        n_ret   = (idx_inc == r_count) ? S_FR_END : S_FR_RD;
                        n_state = S_EMIT;
                    end else begin
                        n_state = (idx_inc == r_count) ? S_FR_END : S_FR_RD;
                    end
                end else begin
                    n_state = S_FR_END;
                end
            end
            S_FR_END: begin
                if (r_idx != '0) begin
                    n_res   = '{status: dltq_pkg::ST_EXPIRED,
                                expired_handle: r_h, last: 1'b1};
                    n_pos   = r_idx;
                    n_ret   = S_CP_INIT;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end

            // Compact: move the survivors down over the fired entries.
            S_CP_INIT: begin
                if (r_idx == r_count) begin
                    n_count = '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CP_RD;
                end
            end
            S_CP_RD: begin
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx - r_pos;
                mem_wdata = r_rdata;
                n_idx     = idx_inc;
                if (idx_inc == r_count) begin
                    n_count = r_count - r_pos;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CP_RD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_idx     <= n_idx;
        r_t       <= n_t;
        r_h       <= n_h;
        r_blocked <= n_blocked;
        r_stop    <= n_stop;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/delta_list_timeout_queue_unit.sv
// The back sequencer finishes each item before it takes the next one, reading the table
// through a single port; meanwhile the front keeps taking items into its command queue.
// Reset (synchronous, active low) empties the table and both queues; the table memory is
// not cleared, since only entries below the live count are ever read.
// ============================================================================
// delta_list_timeout_queue_unit
// Sorted callout queue holding each timeout as a delta from its predecessor.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

// The front accepts each transfer, turns it into a command (insert, tick, or tick that
// only ages the list) and parks it in a two-entry command queue. The back sequencer
// pops one command at a time and works on the table memory through a registered read
// port. Its results go through a four-entry result queue, so a consumer stall reaches
// the front only after both queues fill; the sequencer waits only on a full result queue.
module delta_list_timeout_queue_unit #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  dltq_pkg::t_in  i_data,
    input  wire logic      push,
    output logic           full,
    output dltq_pkg::t_out o_data,
    output logic           empty,
    input  wire logic      pop
);

    dltq_pkg::t_cmd cmd;
    logic           cmd_valid;
    logic           cmd_pop;
    dltq_pkg::t_out res;
    logic           res_push;
    logic           res_full;

    dltq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_data),
        .i_push      (push),
        .o_full      (full),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // The sequencer keeps at most TABLE_ENTRIES - 1 live entries; an insert into a
    // table that already holds that many is answered with a reject status.
    dltq_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    // Result queue: the oldest result sits on o_data while empty is low.
    dltq_fifo #(
        .t_data     (dltq_pkg::t_out),
        .DEPTH_LOG2 (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_data),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

// File: tb/tb_delta_list_timeout_queue_unit.sv
// ============================================================================
// tb_delta_list_timeout_queue_unit
// Self-checking testbench for the delta-list timeout queue. A scoreboard keeps
// its own delta list, predicts the status transfers caused by every insert
// and tick, and compares them in order with what the block returns.
// ============================================================================
`timescale 1ns / 1ps

module tb_delta_list_timeout_queue_unit;

    localparam int DELTA_W  = dltq_pkg::DELTA_W;
    localparam int HANDLE_W = dltq_pkg::HANDLE_W;
    localparam int STATUS_W = dltq_pkg::STATUS_W;

    // Function codes of an input transfer.
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // One slot is always kept free, so at most TABLE_ENTRIES-1 timeouts are live.
    localparam int TABLE_ENTRIES = 16;
    localparam int TABLE_LIMIT   = TABLE_ENTRIES - 1;

    // The long receiver hold-off is the longest stretch without any transfer,
    // and the watchdog limit sits far above it.
    localparam int HOLD_CYCLES  = 2000;
    localparam int IDLE_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_REPORTS  = 40;

    // ------------------------------------------------------------------------
    // Scoreboard: a private copy of the delta list plus the queue of status
    // transfers that the block still owes.
    // ------------------------------------------------------------------------
    class timeout_scoreboard;
        logic [DELTA_W-1:0]  slot_delta  [TABLE_ENTRIES];
        logic [HANDLE_W-1:0] slot_handle [TABLE_ENTRIES];
        int                  live;
        dltq_pkg::t_out      owed_q[$];

        int errors;
        int n_insert, n_reject, n_tick, n_held_tick, n_expired, n_checked;
        int peak_live, widest_burst;

        function new();
            live = 0;
            errors = 0;
            n_insert = 0;
            n_reject = 0;
            n_tick = 0;
            n_held_tick = 0;
            n_expired = 0;
            n_checked = 0;
            peak_live = 0;
            widest_burst = 0;
        endfunction

        function void owe(logic [STATUS_W-1:0] status, logic [HANDLE_W-1:0] handle,
                          logic last);
            dltq_pkg::t_out res;
            res.status = status;
            res.expired_handle = handle;
            res.last = last;
            owed_q.push_back(res);
        endfunction

        function void place_timeout(logic [DELTA_W-1:0] delay, logic [HANDLE_W-1:0] handle);
            logic [DELTA_W-1:0] remain;
            int pos;
            n_insert++;
            if (live >= TABLE_LIMIT) begin
                n_reject++;
                owe(dltq_pkg::ST_REJECT, handle, 1'b1);
                return;
            end
            // Walk past every entry that expires no later than the new one, so
            // equal expiry times keep their arrival order.
            remain = delay;
            pos = 0;
            while (pos < live && slot_delta[pos] <= remain) begin
                remain = remain - slot_delta[pos];
                pos++;
            end
            for (int i = live; i > pos; i--) begin
                slot_delta[i]  = slot_delta[i-1];
                slot_handle[i] = slot_handle[i-1];
            end
            slot_delta[pos]  = remain;
            slot_handle[pos] = handle;
            live++;
            // The follower now counts from the new entry instead of its old one.
            if (pos + 1 < live) slot_delta[pos+1] = slot_delta[pos+1] - remain;
            if (live > peak_live) peak_live = live;
            owe(dltq_pkg::ST_ACCEPT, handle, 1'b1);
        endfunction

        function void age_list(logic blocked);
            int  fired;
            bit  done;
            n_tick++;
            if (blocked) n_held_tick++;
            if (live == 0) return;
            // Only the first positive delta is counted down; leading zeros wait.
            done = 1'b0;
            for (int i = 0; i < live; i++) begin
                if (!done && slot_delta[i] != '0) begin
                    slot_delta[i] = slot_delta[i] - 1'b1;
                    done = 1'b1;
                end
            end
            if (blocked) return;
            fired = 0;
            while (fired < live && slot_delta[fired] == '0) fired++;
            for (int i = 0; i < fired; i++)
                owe(dltq_pkg::ST_EXPIRED, slot_handle[i], i == fired - 1);
            for (int i = fired; i < live; i++) begin
                slot_delta[i-fired]  = slot_delta[i];
                slot_handle[i-fired] = slot_handle[i];
            end
            live = live - fired;
            n_expired += fired;
            if (fired > widest_burst) widest_burst = fired;
        endfunction

        // Called for every input transfer the block accepts.
        function void note_input(dltq_pkg::t_in item);
            if (item.func == FUNC_INSERT) place_timeout(item.delay_ticks, item.handle);
            else age_list(item.blocked);
        endfunction

        // Called for every result transfer the block hands out.
        function void check_result(dltq_pkg::t_out got);
            dltq_pkg::t_out want;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: unexpected result, expected none, ",
                              "got status %0d handle %h last %0d"},
                             $time, got.status, got.expired_handle, got.last);
                return;
            end
            want = owed_q.pop_front();
            n_checked++;
            if (got.status !== want.status) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, got.status);
            end
            if (got.expired_handle !== want.expired_handle) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: handle mismatch, expected %h, got %h",
                             $time, want.expired_handle, got.expired_handle);
            end
            if (got.last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: last mismatch, expected %0d, got %0d",
                             $time, want.last, got.last);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, block and shared control flags.
    // ------------------------------------------------------------------------
    logic           i_clk;
    logic           i_rst_n;
    dltq_pkg::t_in  i_data;
    logic           push;
    logic           full;
    dltq_pkg::t_out o_data;
    logic           empty;
    logic           pop;

    timeout_scoreboard sb = new();

    // Set by the stimulus, read by the result sink. hold_req asks for one long
    // stall of the receiver; quiet turns all random idling off for the tail.
    bit hold_req = 1'b0;
    bit quiet    = 1'b0;
    bit saw_full = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    delta_list_timeout_queue_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_data (i_data),
        .push   (push),
        .full   (full),
        .o_data (o_data),
        .empty  (empty),
        .pop    (pop)
    );

    // ------------------------------------------------------------------------
    // Monitor. Signals are read at the rising edge, before the block and the
    // drivers update them, so a transfer is exactly the handshake seen here.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_input(i_data);
            if (push && full) saw_full = 1'b1;
            if (pop && !empty) sb.check_result(o_data);
        end
    end

    // Watchdog: a run whose idle counter reaches IDLE_LIMIT without any transfer is hung.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results still owed",
                 $time, IDLE_LIMIT, sb.pending());
        $display("delta_list_timeout_queue_unit regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result sink. It alternates random stretches of popping and of stalling,
    // and on request stalls once for HOLD_CYCLES so that the block backs up
    // all the way to its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic dltq_pkg::t_in make_item(logic func, logic [DELTA_W-1:0] delay,
                                                logic [HANDLE_W-1:0] handle, logic blocked);
        dltq_pkg::t_in item;
        item.func = func;
        item.delay_ticks = delay;
        item.handle = handle;
        item.blocked = blocked;
        return item;
    endfunction

    // Random item. Delays are mostly short so that timeouts really expire and
    // the list keeps moving; now and then a mid or a very long one is mixed in.
    function automatic dltq_pkg::t_in random_item(int insert_pct);
        logic [DELTA_W-1:0] delay;
        int pick;
        pick = $urandom_range(0, 199);
        if (pick < 120)      delay = DELTA_W'($urandom_range(0, 1));
        else if (pick < 180) delay = DELTA_W'($urandom_range(2, 5));
        else if (pick < 199) delay = DELTA_W'($urandom_range(6, 40));
        else                 delay = DELTA_W'($urandom);
        if ($urandom_range(0, 99) < insert_pct)
            return make_item(FUNC_INSERT, delay, HANDLE_W'($urandom), 1'($urandom));
        // Ticks carry random junk in the fields they ignore.
        return make_item(FUNC_TICK, DELTA_W'($urandom), HANDLE_W'($urandom),
                         $urandom_range(0, 4) == 0);
    endfunction

    // Offer one item and hold it until the block takes it. push is left high,
    // so back-to-back items keep it high without a glitch.
    task automatic send_item(dltq_pkg::t_in item);
        i_data <= item;
        push <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic sender_gap(int cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Pause the sender until every owed result has been handed out.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int count, int insert_pct, int gap_pct);
        for (int n = 0; n < count; n++) begin
            send_item(random_item(insert_pct));
            if (!quiet && $urandom_range(0, 99) < gap_pct) sender_gap($urandom_range(1, 15));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n <= 1'b0;
        push    <= 1'b0;
        i_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Ticks on an empty list do nothing, held or not.
        send_item(make_item(FUNC_TICK, '1, '1, 1'b0));
        send_item(make_item(FUNC_TICK, '1, '1, 1'b1));
        // Two timeouts due right away; the second one queues behind the first.
        send_item(make_item(FUNC_INSERT, '0, 16'h0000, 1'b0));
        send_item(make_item(FUNC_INSERT, '0, 16'hFFFF, 1'b1));
        // With every delta at zero a held tick changes nothing, and the next
        // tick fires both in one burst.
        send_item(make_item(FUNC_TICK, '0, '0, 1'b1));
        send_item(make_item(FUNC_TICK, '0, '0, 1'b0));
        // The longest delay, then a tick with nothing due.
        send_item(make_item(FUNC_INSERT, '1, 16'hA5A5, 1'b0));
        send_item(make_item(FUNC_TICK, '0, '0, 1'b0));
        // Shorter timeouts slip in ahead of it, two of them with equal delay.
        send_item(make_item(FUNC_INSERT, 15'd3, 16'h5A5A, 1'b0));
        send_item(make_item(FUNC_INSERT, 15'd3, 16'h1234, 1'b0));
        send_item(make_item(FUNC_INSERT, 15'd1, 16'h0F0F, 1'b0));
        // A held tick still ages the head, which then fires on the next tick.
        send_item(make_item(FUNC_TICK, '0, '0, 1'b1));
        send_item(make_item(FUNC_TICK, '0, '0, 1'b0));
        send_item(make_item(FUNC_TICK, '0, '0, 1'b0));
        wait_drained();

        // Random part: each round mixes items, then fills the list until
        // inserts are turned away, then drains it with mostly ticks.
        for (int round = 0; round < 4; round++) begin
            run_phase(40, 50, (round % 2) ? 0 : 25);
            run_phase(30, 85, 25);
            if (round == 1) begin
                // Stall the receiver for a long time while inserts keep coming,
                // so both internal queues fill and the input stalls.
                hold_req = 1'b1;
                run_phase(20, 100, 0);
            end
            run_phase(30, 15, 25);
            if (round == 2) wait_drained();
        end

        // Tail with no idling on either side.
        quiet = 1'b1;
        run_phase(40, 50, 0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d inserts (%0d turned away, peak %0d live), %0d ticks (%0d held)",
                 sb.n_insert, sb.n_reject, sb.peak_live, sb.n_tick, sb.n_held_tick);
        $display("checked %0d results, %0d expirations, widest burst %0d, input stall seen %0d",
                 sb.n_checked, sb.n_expired, sb.widest_burst, saw_full);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("delta_list_timeout_queue_unit regression: pass");
        end else begin
            $display("delta_list_timeout_queue_unit regression: fail");
        end
        $finish;
    end

endmodule
